### hw/rtl/bci_pkg.sv
// shared constants, types and helpers for the breakpoint curve interpolator
`timescale 1ns / 1ps
`default_nettype none
package bci_pkg;

	localparam int NUM_BANKS   = 16;
	localparam int NUM_CURVES  = 12;
	localparam int NUM_POINTS  = 9;

	localparam int CURVE_WORDS = 2 * NUM_POINTS;
	localparam int STORE_WORDS = NUM_BANKS * NUM_CURVES * CURVE_WORDS;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int K_W         = $clog2(NUM_POINTS + 1);

	localparam int CURVE_FLD_W = 4;
	localparam int BANK_FLD_W  = 4;
	localparam int WIDX_FLD_W  = 5;
	localparam int WORD_W      = 32;
	localparam int LEVEL_W     = 7;

	localparam int SPAN_W      = WORD_W + 1;
	localparam int PROD_W      = 2 * SPAN_W;
	localparam int CNT_W       = $clog2(PROD_W + 1);
	localparam int QSAT_LOG2   = 40;
	localparam int R_W         = QSAT_LOG2 + 3;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'h7F;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_FETCH_RD,
		ST_FETCH_CAP,
		ST_CALC,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		F_LOP,
		F_LOV,
		F_HIV
	} fetch_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV,
		PH_END
	} phase_t;

	typedef struct packed {
		logic start;
		logic flat;
	} arith_cmd_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] level;
	} arith_rsp_t;

	function automatic logic [SPAN_W-1:0] mag(input logic signed [SPAN_W-1:0] d);
		logic signed [SPAN_W-1:0] n;
		n = -d;
		return d[SPAN_W-1] ? $unsigned(n) : $unsigned(d);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/bci_ram.sv
// single-port synchronous ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module bci_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bci_arith.sv
// bit-serial span multiply, restoring divide and level clamp
`timescale 1ns / 1ps
`default_nettype none
module bci_arith import bci_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire arith_cmd_t               cmd,
	input  wire logic signed [WORD_W-1:0] lo_p,
	input  wire logic signed [WORD_W-1:0] hi_p,
	input  wire logic signed [WORD_W-1:0] lo_v,
	input  wire logic signed [WORD_W-1:0] hi_v,
	input  wire logic signed [WORD_W-1:0] pos,
	output arith_rsp_t                    rsp
);

	phase_t phase_q, phase_d;

	logic [SPAN_W-1:0]        mcand_q;
	logic [SPAN_W-1:0]        dvs_q;
	logic [SPAN_W-1:0]        rem_q;
	logic [PROD_W-1:0]        prod_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic signed [WORD_W-1:0] lo_v_q;

	logic signed [SPAN_W-1:0] den, dv, dp;
	logic                     den_zero;
	logic [SPAN_W:0]          mul_sum;
	logic [SPAN_W:0]          rem_sh, rem_diff;
	logic                     rem_ge;
	logic                     q_sat;
	logic [QSAT_LOG2:0]       q_lim;
	logic signed [R_W-1:0]    r;

	assign den      = SPAN_W'(hi_p) - SPAN_W'(lo_p);
	assign dv       = SPAN_W'(hi_v) - SPAN_W'(lo_v);
	assign dp       = SPAN_W'(pos) - SPAN_W'(lo_p);
	assign den_zero = (den == '0);

	assign mul_sum  = {1'b0, prod_q[PROD_W-1:SPAN_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
	assign rem_sh   = {rem_q, prod_q[PROD_W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign rem_ge   = (rem_sh >= {1'b0, dvs_q});

	assign q_sat = (prod_q > (PROD_W'(1) << QSAT_LOG2));
	assign q_lim = q_sat ? ((QSAT_LOG2 + 1)'(1) << QSAT_LOG2) : prod_q[QSAT_LOG2:0];
	assign r     = neg_q ? (R_W'(lo_v_q) - $signed(R_W'(q_lim)))
	                     : (R_W'(lo_v_q) + $signed(R_W'(q_lim)));

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (cmd.start) begin
					phase_d = (cmd.flat || den_zero) ? PH_END : PH_MUL;
				end
			end
			PH_MUL: begin
				if (cnt_q == '0) begin
					phase_d = PH_DIV;
				end
			end
			PH_DIV: begin
				if (cnt_q == '0) begin
					phase_d = PH_END;
				end
			end
			PH_END: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp = '0;
		case (phase_q)
			PH_END: begin
				rsp.done = 1'b1;
				if (r[R_W-1]) begin
					rsp.level = '0;
				end else if (|r[R_W-2:LEVEL_W]) begin
					rsp.level = LEVEL_MAX;
				end else begin
					rsp.level = r[LEVEL_W-1:0];
				end
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (cmd.start) begin
					mcand_q <= mag(dv);
					dvs_q   <= mag(den);
					neg_q   <= (dv[SPAN_W-1] ^ dp[SPAN_W-1]) ^ den[SPAN_W-1];
					lo_v_q  <= lo_v;
					rem_q   <= '0;
					cnt_q   <= CNT_W'(SPAN_W - 1);
					if (cmd.flat || den_zero) begin
						prod_q <= '0;
					end else begin
						prod_q <= {{SPAN_W{1'b0}}, mag(dp)};
					end
				end
			end
			PH_MUL: begin
				prod_q <= {mul_sum, prod_q[SPAN_W-1:1]};
				if (cnt_q == '0) begin
					cnt_q <= CNT_W'(PROD_W - 1);
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			PH_DIV: begin
				rem_q  <= rem_ge ? rem_diff[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], rem_ge};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> phase_q == PH_IDLE)
		else $error("arith start while busy");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIV |-> dvs_q != '0)
		else $error("divide by zero span");

	a_mul_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MUL && cnt_q == '0) |=> phase_q == PH_DIV)
		else $error("multiply did not hand over to divide");

endmodule
`default_nettype wire

### hw/rtl/breakpoint_curve_interpolator_core.sv
// top level: curve store, breakpoint scan sequencer and result register
//
// channel  dir  handshake              payload
// req      in   req_valid/req_stall    func curve bank word_index write_word position
// rsp      out  rsp_valid/rsp_stall    level
//
// an in-range write item lands in the single-port curve ram at the accept edge
// an evaluate item scans breakpoints with a read and a compare each over the one ram port, fetches
// three words (only the last value when the position lies past the last breakpoint), then runs a
// 33-step serial multiply and a 66-step serial divide, both skipped in that case or for a flat span
// the store has no reset; arst_n clears only the sequencer, the arithmetic phase and the result valid
// a waiting result is held in its own register; a later item is taken while it waits
`timescale 1ns / 1ps
`default_nettype none
module breakpoint_curve_interpolator_core import bci_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire logic                     func,
	input  wire logic [CURVE_FLD_W-1:0]   curve,
	input  wire logic [BANK_FLD_W-1:0]    bank,
	input  wire logic [WIDX_FLD_W-1:0]    word_index,
	input  wire logic signed [WORD_W-1:0] write_word,
	input  wire logic signed [WORD_W-1:0] position,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic [LEVEL_W-1:0]            level
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]        base_q;
	logic signed [WORD_W-1:0] pos_q;
	logic [K_W-1:0]           k_q;
	fetch_t                   fetch_q;
	logic                     last_q;
	logic signed [WORD_W-1:0] lo_p_q, hi_p_q, lo_v_q, hi_v_q;
	logic [LEVEL_W-1:0]       res_q;
	logic                     rsp_valid_q;
	logic [LEVEL_W-1:0]       level_q;

	logic              accept;
	logic              in_range;
	logic              widx_ok;
	logic [ADDR_W-1:0] base_in;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_rdata;
	logic              hit;
	logic              out_free;
	arith_cmd_t        arith_cmd;
	arith_rsp_t        arith_rsp;

	assign accept   = req_valid && !req_stall;
	assign in_range = (32'(curve) < NUM_CURVES) && (32'(bank) < NUM_BANKS);
	assign widx_ok  = (32'(word_index) < CURVE_WORDS);
	assign base_in  = ADDR_W'((32'(bank) * NUM_CURVES + 32'(curve)) * CURVE_WORDS);
	assign hit      = (pos_q < $signed(ram_rdata));
	assign out_free = !(rsp_valid_q && rsp_stall);

	bci_ram #(
		.DATA_W(WORD_W),
		.DEPTH (STORE_WORDS),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(write_word),
		.rdata(ram_rdata)
	);

	bci_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (arith_cmd),
		.lo_p  (lo_p_q),
		.hi_p  (hi_p_q),
		.lo_v  (lo_v_q),
		.hi_v  (hi_v_q),
		.pos   (pos_q),
		.rsp   (arith_rsp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && func == FUNC_EVAL) begin
					state_d = in_range ? ST_SCAN_RD : ST_OUT;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (!hit && k_q != K_W'(NUM_POINTS - 1)) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_FETCH_RD;
				end
			end
			ST_FETCH_RD: begin
				state_d = ST_FETCH_CAP;
			end
			ST_FETCH_CAP: begin
				if (last_q || fetch_q == F_HIV) begin
					state_d = ST_CALC;
				end else begin
					state_d = ST_FETCH_RD;
				end
			end
			ST_CALC: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (arith_rsp.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = base_q + ADDR_W'(k_q);
		arith_cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				ram_addr  = base_in + ADDR_W'(word_index);
				ram_we    = accept && func == FUNC_WRITE && in_range && widx_ok;
			end
			ST_SCAN_RD: begin
				ram_re = 1'b1;
			end
			ST_FETCH_RD: begin
				ram_re = 1'b1;
				case (fetch_q)
					F_LOP: ram_addr = base_q + ADDR_W'(k_q) - ADDR_W'(1);
					F_LOV: ram_addr = base_q + ADDR_W'(NUM_POINTS) + ADDR_W'(k_q) - ADDR_W'(1);
					F_HIV: ram_addr = base_q + ADDR_W'(NUM_POINTS) + ADDR_W'(k_q);
					default: ram_addr = base_q;
				endcase
			end
			ST_CALC: begin
				arith_cmd.start = 1'b1;
				arith_cmd.flat  = last_q;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q  <= base_in;
					pos_q   <= position;
					k_q     <= K_W'(1);
					last_q  <= 1'b0;
					fetch_q <= F_LOP;
					res_q   <= '0;
				end
			end
			ST_SCAN_CMP: begin
				if (hit) begin
					hi_p_q <= ram_rdata;
				end else if (k_q == K_W'(NUM_POINTS - 1)) begin
					k_q     <= K_W'(NUM_POINTS);
					last_q  <= 1'b1;
					fetch_q <= F_LOV;
				end else begin
					k_q <= k_q + K_W'(1);
				end
			end
			ST_FETCH_CAP: begin
				case (fetch_q)
					F_LOP: begin
						lo_p_q  <= ram_rdata;
						fetch_q <= F_LOV;
					end
					F_LOV: begin
						lo_v_q  <= ram_rdata;
						fetch_q <= F_HIV;
					end
					F_HIV: begin
						hi_v_q <= ram_rdata;
					end
					default: begin
						fetch_q <= F_LOP;
					end
				endcase
			end
			ST_WAIT: begin
				if (arith_rsp.done) begin
					res_q <= arith_rsp.level;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					level_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign level     = level_q;

	a_eval_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_EVAL) |=> state_q != ST_IDLE)
		else $error("evaluate item left the sequencer idle");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_RD |-> (k_q >= K_W'(1) && k_q <= K_W'(NUM_POINTS - 1)))
		else $error("scan index out of range");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> rsp_valid_q)
		else $error("result not presented");

endmodule
`default_nettype wire

### tb/sv/breakpoint_curve_interpolator_core_tb.sv
// self-checking testbench for the breakpoint curve interpolator core
`timescale 1ns / 1ps
module breakpoint_curve_interpolator_core_tb;
	import bci_pkg::*;

	localparam longint LIMIT_CYCLES = 2_000_000;
	localparam int END_CYCLES = 300;
	localparam int HOLD_CYCLES = 1500;
	localparam longint unsigned Q_LIMIT = 64'd1 << QSAT_LOG2;
	localparam int NUM_SLOTS = NUM_BANKS * NUM_CURVES;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic func = FUNC_WRITE;
	logic [CURVE_FLD_W-1:0] curve = '0;
	logic [BANK_FLD_W-1:0] bank = '0;
	logic [WIDX_FLD_W-1:0] word_index = '0;
	logic signed [WORD_W-1:0] write_word = '0;
	logic signed [WORD_W-1:0] position = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [LEVEL_W-1:0] level;

	logic signed [WORD_W-1:0] curve_words [STORE_WORDS];
	logic signed [WORD_W-1:0] pts [NUM_POINTS];
	logic signed [WORD_W-1:0] vals [NUM_POINTS];
	logic [LEVEL_W-1:0] levels_due [$];
	logic [LEVEL_W-1:0] oldest_level;
	bit slot_ready [NUM_SLOTS];
	int slots_loaded [$];

	int req_gap_pct = 0;
	int rsp_stall_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int errors = 0;
	int items_taken = 0;
	longint cycles = 0;

	breakpoint_curve_interpolator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.curve(curve),
		.bank(bank),
		.word_index(word_index),
		.write_word(write_word),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.level(level)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stall, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_done != hold_req) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (levels_due.size() == 0) begin
				$error("level: no result expected, got %0d", level);
				errors++;
			end else begin
				oldest_level = levels_due.pop_front();
				if (level !== oldest_level) begin
					$error("level: expected %0d, got %0d", oldest_level, level);
					errors++;
				end
			end
		end
	end

	function automatic logic [LEVEL_W-1:0] clamp_level(longint r);
		if (r < 0)
			return '0;
		if (r > longint'(LEVEL_MAX))
			return LEVEL_MAX;
		return r[LEVEL_W-1:0];
	endfunction

	function automatic longint unsigned magnitude(longint d);
		return d < 0 ? $unsigned(-d) : $unsigned(d);
	endfunction

	function automatic logic [LEVEL_W-1:0] curve_level(int base, logic signed [WORD_W-1:0] pos);
		int k;
		longint lo_p, hi_p, lo_v, hi_v, den, dv, dp, r;
		longint unsigned q;
		bit neg;
		k = 1;
		while (k < NUM_POINTS && pos >= curve_words[base + k])
			k++;
		if (k >= NUM_POINTS)
			return clamp_level(curve_words[base + CURVE_WORDS - 1]);
		lo_p = curve_words[base + k - 1];
		hi_p = curve_words[base + k];
		lo_v = curve_words[base + NUM_POINTS + k - 1];
		hi_v = curve_words[base + NUM_POINTS + k];
		den = hi_p - lo_p;
		if (den == 0)
			return clamp_level(lo_v);
		dv = hi_v - lo_v;
		dp = longint'(pos) - lo_p;
		neg = ((dv < 0) != (dp < 0)) != (den < 0);
		q = magnitude(dv) * magnitude(dp) / magnitude(den);
		if (q > Q_LIMIT)
			q = Q_LIMIT;
		r = neg ? lo_v - longint'(q) : lo_v + longint'(q);
		return clamp_level(r);
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_position(int slot);
		int base, k, sel;
		longint lo, span;
		base = slot * CURVE_WORDS;
		k = $urandom_range(0, NUM_POINTS - 1);
		sel = $urandom_range(0, 9);
		lo = curve_words[base + k];
		if (sel < 5)
			return lo + $urandom_range(0, 6) - 3;
		if (sel < 8 && k < NUM_POINTS - 1) begin
			span = longint'(curve_words[base + k + 1]) - lo;
			if (span > 0)
				return lo + longint'($urandom) % span;
			return lo;
		end
		if (sel == 8)
			return lo - $urandom_range(1, 50);
		return $urandom;
	endfunction

	task automatic send_item(logic f, int c, int b, int w, logic [WORD_W-1:0] ww,
			logic [WORD_W-1:0] pos);
		int base;
		while ($urandom_range(0, 99) < req_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		curve <= c[CURVE_FLD_W-1:0];
		bank <= b[BANK_FLD_W-1:0];
		word_index <= w[WIDX_FLD_W-1:0];
		write_word <= ww;
		position <= pos;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		base = (b * NUM_CURVES + c) * CURVE_WORDS;
		if (f == FUNC_WRITE) begin
			if (c < NUM_CURVES && w < CURVE_WORDS) begin
				curve_words[base + w] = ww;
				items_taken++;
			end
		end else begin
			levels_due.push_back(c < NUM_CURVES ? curve_level(base, pos) : '0);
			items_taken++;
		end
	endtask

	task automatic evaluate_at(int b, int c, logic [WORD_W-1:0] pos);
		send_item(FUNC_EVAL, c, b, $urandom_range(0, 31), $urandom, pos);
	endtask

	task automatic load_curve(int b, int c);
		int slot;
		slot = b * NUM_CURVES + c;
		for (int k = 0; k < CURVE_WORDS; k++)
			send_item(FUNC_WRITE, c, b, k, k < NUM_POINTS ? pts[k] : vals[k - NUM_POINTS],
				$urandom);
		if (!slot_ready[slot]) begin
			slot_ready[slot] = 1'b1;
			slots_loaded.push_back(slot);
		end
	endtask

	task automatic make_curve();
		int shape;
		shape = $urandom_range(0, 9);
		if (shape < 6) begin
			pts[0] = int'($urandom_range(0, 2000)) - 1000;
			for (int k = 1; k < NUM_POINTS; k++)
				pts[k] = pts[k - 1] + $urandom_range(0, 40);
			if ($urandom_range(0, 3) == 0)
				pts[1] = pts[0];
			for (int k = 0; k < NUM_POINTS; k++)
				vals[k] = int'($urandom_range(0, 220)) - 50;
		end else if (shape < 8) begin
			pts[0] = 32'h8000_0000 + $urandom_range(0, 1000);
			for (int k = 1; k < NUM_POINTS; k++)
				pts[k] = pts[k - 1] + $urandom_range(1, 1 << 28);
			for (int k = 0; k < NUM_POINTS; k++)
				vals[k] = $urandom;
		end else begin
			for (int k = 0; k < NUM_POINTS; k++) begin
				pts[k] = $urandom;
				vals[k] = int'($urandom_range(0, 600)) - 300;
			end
		end
	endtask

	task automatic wait_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (levels_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_curve_extremes();
		req_gap_pct = 10;
		rsp_stall_pct <= 68;
		pts = '{32'sh8000_0000, -1000, -10, 0, 0, 10, 1000, 100000, 32'sh7fff_ffff};
		vals = '{32'sh8000_0000, 0, 127, 128, 5, 32'sh7fff_ffff, 64, -1, 100};
		load_curve(15, 11);
		evaluate_at(15, 11, 32'h8000_0000);
		evaluate_at(15, 11, 32'h7fff_ffff);
		evaluate_at(15, 11, -5);
		evaluate_at(15, 11, 0);
		evaluate_at(15, 11, 7);
		evaluate_at(15, 11, 500);
		evaluate_at(15, 11, 99999);
		evaluate_at(15, 11, 100000);
	endtask

	task automatic test_flat_and_descending();
		// first two positions equal: zero span below them
		send_item(FUNC_WRITE, 11, 15, 0, -1000, $urandom);
		evaluate_at(15, 11, -2000);
		send_item(FUNC_WRITE, 11, 15, NUM_POINTS, 50, $urandom);
		evaluate_at(15, 11, -5000);
		// descending first span, huge quotient
		send_item(FUNC_WRITE, 11, 15, 0, 5000, $urandom);
		send_item(FUNC_WRITE, 11, 15, 1, 4999, $urandom);
		send_item(FUNC_WRITE, 11, 15, NUM_POINTS + 1, 32'h7fff_ffff, $urandom);
		evaluate_at(15, 11, 32'h8000_0000);
		evaluate_at(15, 11, 4000);
		send_item(FUNC_WRITE, 11, 15, NUM_POINTS + 1, 32'h8000_0000, $urandom);
		evaluate_at(15, 11, 4000);
	endtask

	task automatic test_out_of_range();
		evaluate_at(0, NUM_CURVES, $urandom);
		evaluate_at(15, 15, $urandom);
		send_item(FUNC_WRITE, 13, 2, 0, $urandom, $urandom);
		send_item(FUNC_WRITE, 11, 15, CURVE_WORDS, 32'h0, $urandom);
		send_item(FUNC_WRITE, 11, 15, 31, 32'hffff_ffff, $urandom);
		evaluate_at(15, 11, 50);
	endtask

	task automatic test_random_traffic(int gap_pct, int stall_pct, int n);
		int target, slot, b, c, w, base;
		logic [WORD_W-1:0] word;
		req_gap_pct = gap_pct;
		rsp_stall_pct <= stall_pct;
		target = items_taken + n;
		while (items_taken < target) begin
			if (slots_loaded.size() == 0 || $urandom_range(0, 2) == 0) begin
				b = $urandom_range(0, NUM_BANKS - 1);
				c = $urandom_range(0, NUM_CURVES - 1);
				make_curve();
				load_curve(b, c);
				slot = b * NUM_CURVES + c;
			end else begin
				slot = slots_loaded[$urandom_range(0, slots_loaded.size() - 1)];
				base = slot * CURVE_WORDS;
				repeat ($urandom_range(1, 3)) begin
					w = $urandom_range(0, CURVE_WORDS - 1);
					word = $urandom_range(0, 1) ? $urandom
						: curve_words[base + w] + $urandom_range(0, 20) - 10;
					send_item(FUNC_WRITE, slot % NUM_CURVES, slot / NUM_CURVES, w, word,
						$urandom);
				end
			end
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 4) == 0)
					slot = slots_loaded[$urandom_range(0, slots_loaded.size() - 1)];
				evaluate_at(slot / NUM_CURVES, slot % NUM_CURVES, pick_position(slot));
			end
			case ($urandom_range(0, 5))
				0: send_item(FUNC_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(CURVE_WORDS, 31), $urandom, $urandom);
				1: send_item(FUNC_WRITE, $urandom_range(NUM_CURVES, 15), $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom, $urandom);
				2: evaluate_at($urandom_range(0, 15), $urandom_range(NUM_CURVES, 15), $urandom);
				3: send_item(FUNC_WRITE, $urandom_range(0, NUM_CURVES - 1),
					$urandom_range(0, 15), $urandom_range(0, CURVE_WORDS - 1), $urandom,
					$urandom);
				default: ;
			endcase
		end
	endtask

	task automatic test_output_backpressure();
		int slot;
		req_gap_pct = 0;
		rsp_stall_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (16) begin
			slot = slots_loaded[$urandom_range(0, slots_loaded.size() - 1)];
			evaluate_at(slot / NUM_CURVES, slot % NUM_CURVES, pick_position(slot));
		end
	endtask

	task automatic test_sender_pause();
		int slot;
		wait_results();
		req_gap_pct = 0;
		rsp_stall_pct <= 30;
		repeat (6) begin
			slot = slots_loaded[$urandom_range(0, slots_loaded.size() - 1)];
			evaluate_at(slot / NUM_CURVES, slot % NUM_CURVES, pick_position(slot));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_curve_extremes();
		test_flat_and_descending();
		test_out_of_range();
		test_random_traffic(10, 68, 560);
		test_output_backpressure();
		test_sender_pause();
		test_random_traffic(68, 10, 560);
		test_random_traffic(0, 0, 560);
		wait_results();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0 && levels_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
hw/rtl/bci_pkg.sv
hw/rtl/bci_ram.sv
hw/rtl/bci_arith.sv
hw/rtl/breakpoint_curve_interpolator_core.sv
tb/sv/breakpoint_curve_interpolator_core_tb.sv
